/* rtl/core/bclm_pkg.sv */
// ----------------------------------------------------------------------------
// Battery charge level monitor package
// Shared widths, word types, register indexes, reset values and constants.
// ----------------------------------------------------------------------------
package bclm_pkg;

   localparam int MV_W       = 13;
   localparam int TIME_W     = 32;
   localparam int RUN_W      = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      LVL_NORMAL = 2'd0,
      LVL_LOW    = 2'd1,
      LVL_CUTOFF = 2'd2
   } level_type;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NO_CELL_MV      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USB_ON_MV       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USB_OFF_MV      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_STEP_MV  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_MV       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV          = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER_MV      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_REPEAT_MS = 4'd7;

   // Tracking constants.
   localparam logic [TIME_W-1:0]      SLOPE_WINDOW_MS = 32'd60000;
   localparam logic signed [MV_W:0]   HOLD_RISE_MV    = 14'sd5;
   localparam logic signed [MV_W:0]   SAG_LIMIT_MV    = 14'sd20;
   localparam logic signed [MV_W:0]   RISE_STEP_MV    = 14'sd15;
   localparam logic [RUN_W-1:0]       RISE_WINDOWS    = 4'd3;
   localparam logic [RUN_W-1:0]       CUTOFF_SAMPLES  = 4'd3;
   localparam logic [RUN_W-1:0]       RUN_MAX         = 4'd15;

   typedef struct packed {
      logic              func;
      logic [MV_W-1:0]   sample_mv;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      level_type       level_state;
      logic            usb_present;
      logic            charging;
      logic            alert_due;
      logic [MV_W-1:0] average_mv;
   } rsp_type;

   typedef struct packed {
      logic [MV_W-1:0]   no_cell_mv;
      logic [MV_W-1:0]   usb_on_mv;
      logic [MV_W-1:0]   usb_off_mv;
      logic [MV_W-1:0]   charge_step_mv;
      logic [MV_W-1:0]   cutoff_mv;
      logic [MV_W-1:0]   low_mv;
      logic [MV_W-1:0]   recover_mv;
      logic [TIME_W-1:0] alert_repeat_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      no_cell_mv:      13'd2500,
      usb_on_mv:       13'd4150,
      usb_off_mv:      13'd4100,
      charge_step_mv:  13'd40,
      cutoff_mv:       13'd3300,
      low_mv:          13'd3500,
      recover_mv:      13'd3600,
      alert_repeat_ms: 32'd60000
   };

   typedef struct packed {
      level_type         level;
      logic [MV_W-1:0]   average;
      logic [RUN_W-1:0]  cutoff_run;
      logic              entry_pulse;
      logic              usb_latch;
      logic              charge_flag;
      logic [MV_W-1:0]   previous_sample;
      logic [MV_W-1:0]   slope_anchor_mv;
      logic [TIME_W-1:0] slope_anchor_time;
      logic              slope_armed;
      logic [RUN_W-1:0]  rise_run;
      logic [TIME_W-1:0] last_alert_time;
   } state_type;

endpackage

/* rtl/core/bclm_update.sv */
// ----------------------------------------------------------------------------
// Battery monitor update logic
// Next-state and result word for one sample or alert poll.
// ----------------------------------------------------------------------------
module bclm_update (
   input  bclm_pkg::cfg_type   cfg,
   input  bclm_pkg::state_type cur,
   input  bclm_pkg::req_type   item,
   output bclm_pkg::state_type nxt,
   output bclm_pkg::rsp_type   result
);
   import bclm_pkg::*;

   logic [MV_W+1:0] avg_sum;
   logic [MV_W-1:0] avg_blend;

   // Three parts old average to one part new sample.
   assign avg_sum   = ({2'b00, cur.average} << 1) + {2'b00, cur.average}
                      + {2'b00, item.sample_mv};
   assign avg_blend = avg_sum[MV_W+1:2];

   always_comb begin
      logic signed [MV_W:0] diff;
      logic signed [MV_W:0] step_mv;
      logic signed [MV_W:0] drift;
      logic [TIME_W-1:0]    slope_age;
      logic [TIME_W-1:0]    alert_age;
      logic                 stepped;
      logic                 due;

      nxt       = cur;
      due       = 1'b0;
      stepped   = 1'b0;
      diff      = signed'({1'b0, item.sample_mv}) - signed'({1'b0, cur.previous_sample});
      step_mv   = signed'({1'b0, cfg.charge_step_mv});
      drift     = '0;
      slope_age = item.now_ms - cur.slope_anchor_time;
      alert_age = item.now_ms - cur.last_alert_time;

      if (!item.func) begin
         if (item.sample_mv < cfg.no_cell_mv) begin
            // No cell: back to inert, keeping the slope anchor level and alert time.
            nxt.level             = LVL_NORMAL;
            nxt.average           = '0;
            nxt.cutoff_run        = '0;
            nxt.entry_pulse       = 1'b0;
            nxt.usb_latch         = 1'b0;
            nxt.charge_flag       = 1'b0;
            nxt.previous_sample   = '0;
            nxt.slope_anchor_time = '0;
            nxt.slope_armed       = 1'b0;
            nxt.rise_run          = '0;
         end else begin
            nxt.average = (cur.average != '0) ? avg_blend : item.sample_mv;

            if (!cur.usb_latch && nxt.average >= cfg.usb_on_mv) begin
               nxt.usb_latch = 1'b1;
            end else if (cur.usb_latch && nxt.average < cfg.usb_off_mv) begin
               nxt.usb_latch = 1'b0;
            end

            // Plug and unplug steps between consecutive samples.
            if (cur.previous_sample != '0) begin
               if (!nxt.usb_latch && !cur.charge_flag && diff >= step_mv) begin
                  nxt.charge_flag = 1'b1;
                  stepped         = 1'b1;
               end else if ((cur.charge_flag || nxt.usb_latch) && (-diff) >= step_mv) begin
                  nxt.charge_flag = 1'b0;
                  nxt.usb_latch   = 1'b0;
                  stepped         = 1'b1;
               end
            end

            drift = signed'({1'b0, nxt.average}) - signed'({1'b0, cur.slope_anchor_mv});

            if (!cur.slope_armed || stepped) begin
               nxt.slope_anchor_mv   = nxt.average;
               nxt.slope_anchor_time = item.now_ms;
               nxt.slope_armed       = 1'b1;
               nxt.rise_run          = '0;
            end else if (slope_age >= SLOPE_WINDOW_MS) begin
               if (nxt.charge_flag && drift < HOLD_RISE_MV) begin
                  nxt.charge_flag = 1'b0;
               end
               if (nxt.usb_latch && drift <= -SAG_LIMIT_MV) begin
                  nxt.usb_latch = 1'b0;
               end
               if (!nxt.usb_latch && !nxt.charge_flag && drift >= RISE_STEP_MV) begin
                  if (cur.rise_run != RUN_MAX) begin
                     nxt.rise_run = cur.rise_run + 4'd1;
                  end
                  if (nxt.rise_run >= RISE_WINDOWS) begin
                     nxt.charge_flag = 1'b1;
                  end
               end else begin
                  nxt.rise_run = '0;
               end
               nxt.slope_anchor_mv   = nxt.average;
               nxt.slope_anchor_time = item.now_ms;
            end

            if (nxt.usb_latch) begin
               nxt.charge_flag = 1'b0;
            end
            nxt.previous_sample = item.sample_mv;

            // A latched cutoff freezes the level and the cutoff debounce.
            if (cur.level != LVL_CUTOFF) begin
               if (item.sample_mv < cfg.cutoff_mv) begin
                  if (cur.cutoff_run != RUN_MAX) begin
                     nxt.cutoff_run = cur.cutoff_run + 4'd1;
                  end
               end else begin
                  nxt.cutoff_run = '0;
               end
               if (nxt.cutoff_run >= CUTOFF_SAMPLES) begin
                  nxt.level = LVL_CUTOFF;
               end else if (cur.level == LVL_NORMAL && nxt.average < cfg.low_mv) begin
                  nxt.level       = LVL_LOW;
                  nxt.entry_pulse = 1'b1;
               end else if (cur.level == LVL_LOW && nxt.average >= cfg.recover_mv) begin
                  nxt.level       = LVL_NORMAL;
                  nxt.entry_pulse = 1'b0;
               end
            end
         end
      end else if (cur.level == LVL_LOW) begin
         if (cur.entry_pulse) begin
            nxt.entry_pulse     = 1'b0;
            nxt.last_alert_time = item.now_ms;
            due                 = 1'b1;
         end else if (alert_age >= cfg.alert_repeat_ms) begin
            nxt.last_alert_time = item.now_ms;
            due                 = 1'b1;
         end
      end

      result.level_state = nxt.level;
      result.usb_present = nxt.usb_latch;
      result.charging    = nxt.charge_flag;
      result.alert_due   = due;
      result.average_mv  = nxt.average;
   end

endmodule

/* rtl/core/battery_charge_level_monitor.sv */
// The input and result registers hold one word each; an accepted word moves on when
// the result register is empty or being taken, one word per cycle unless stalled.
// The whole update for a word is one pass through the update logic between them.
// Reset (synchronous, active high) restores the config, state and valid registers
// to their defaults and the monitor to the inert state; there is no clearing pass.
// ----------------------------------------------------------------------------
// Battery charge level monitor
// Tracks average cell voltage, USB presence, charging, cutoff and low alerts.
// ----------------------------------------------------------------------------
module battery_charge_level_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bclm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bclm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wen,
   input  logic [bclm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bclm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bclm_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in, upd_state;
   req_type   in_data_ff;
   rsp_type   rsp_data_ff, upd_rsp;
   logic      in_valid_ff, in_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      advance, req_accept;

   // The held word moves on when the result register is empty or being taken.
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign state_in     = advance ? upd_state : state_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_NO_CELL_MV:      cfg_in.no_cell_mv      = csr_wdata[MV_W-1:0];
            CSR_USB_ON_MV:       cfg_in.usb_on_mv       = csr_wdata[MV_W-1:0];
            CSR_USB_OFF_MV:      cfg_in.usb_off_mv      = csr_wdata[MV_W-1:0];
            CSR_CHARGE_STEP_MV:  cfg_in.charge_step_mv  = csr_wdata[MV_W-1:0];
            CSR_CUTOFF_MV:       cfg_in.cutoff_mv       = csr_wdata[MV_W-1:0];
            CSR_LOW_MV:          cfg_in.low_mv          = csr_wdata[MV_W-1:0];
            CSR_RECOVER_MV:      cfg_in.recover_mv      = csr_wdata[MV_W-1:0];
            CSR_ALERT_REPEAT_MS: cfg_in.alert_repeat_ms = csr_wdata[TIME_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   bclm_update u_update (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (in_data_ff),
      .nxt    (upd_state),
      .result (upd_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= upd_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // An alert can only be reported while the level is low.
   a_alert_only_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.alert_due |-> rsp_data_ff.level_state == LVL_LOW)
      else $error("alert reported outside the low level");

   // USB presence always overrides the charging flag.
   a_usb_excludes_charge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.usb_present && rsp_data_ff.charging))
      else $error("usb present and charging both set");

   // Only a no-cell sample releases a latched cutoff.
   a_cutoff_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.level == LVL_CUTOFF
      && !(advance && !in_data_ff.func && in_data_ff.sample_mv < cfg_ff.no_cell_mv)
      |=> state_ff.level == LVL_CUTOFF)
      else $error("cutoff latch released without a no-cell sample");

   // A held word that cannot move on stays in the input register.
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held input word lost");
`endif

endmodule

/* verif/tb_battery_charge_level_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery charge level monitor testbench
// Feeds sample and poll words through the monitor under several register
// settings and idle patterns, predicts every result word and checks it.
// ----------------------------------------------------------------------------
module tb_battery_charge_level_monitor;
   import bclm_pkg::*;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_POLL   = 1'b1;

   localparam logic [TIME_W-1:0] WINDOW_MS = 32'd60000;
   localparam int HOLD_MV         = 5;
   localparam int SAG_MV          = 20;
   localparam int RISE_MV         = 15;
   localparam int RISE_COUNT      = 3;
   localparam int CUTOFF_COUNT    = 3;
   localparam int RUN_LIMIT       = 15;
   localparam int FIRST_UNUSED_INDEX = 8;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_PAUSE     = 4;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 125;

   typedef enum int {SET_DEFAULT, SET_ZERO, SET_MAX, SET_TYPICAL, SET_WILD} setting_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type pending_words[$];
   rsp_type expected_status[$];
   cfg_type shadow_regs;
   state_type shadow_state;
   rsp_type want_status;

   logic word_taken = 1'b0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int failures = 0;
   int words_taken = 0;
   int results_checked = 0;
   int settings_applied = 0;
   int alerts_seen = 0;
   int cutoff_seen = 0;
   int charging_seen = 0;
   int usb_seen = 0;

   battery_charge_level_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advances the shadow monitor by one word and returns the status it reports.
   function automatic rsp_type predict_status(input req_type word);
      rsp_type status;
      int mv;
      int diff;
      int slope;
      int step_mv;
      int blend;
      logic stepped;
      logic due;
      logic [TIME_W-1:0] elapsed;
      mv = word.sample_mv;
      step_mv = shadow_regs.charge_step_mv;
      stepped = 1'b0;
      due = 1'b0;
      if (word.func == FUNC_POLL) begin
         if (shadow_state.level == LVL_LOW) begin
            elapsed = word.now_ms - shadow_state.last_alert_time;
            if (shadow_state.entry_pulse) begin
               shadow_state.entry_pulse = 1'b0;
               shadow_state.last_alert_time = word.now_ms;
               due = 1'b1;
            end else if (elapsed >= shadow_regs.alert_repeat_ms) begin
               shadow_state.last_alert_time = word.now_ms;
               due = 1'b1;
            end
         end
      end else if (mv < shadow_regs.no_cell_mv) begin
         // No cell: everything but the slope anchor level and alert time goes inert.
         shadow_state.level = LVL_NORMAL;
         shadow_state.average = '0;
         shadow_state.cutoff_run = '0;
         shadow_state.entry_pulse = 1'b0;
         shadow_state.usb_latch = 1'b0;
         shadow_state.charge_flag = 1'b0;
         shadow_state.previous_sample = '0;
         shadow_state.slope_anchor_time = '0;
         shadow_state.slope_armed = 1'b0;
         shadow_state.rise_run = '0;
      end else begin
         if (shadow_state.average != 0) begin
            blend = int'(shadow_state.average) * 3 + mv;
            shadow_state.average = MV_W'(blend / 4);
         end else begin
            shadow_state.average = word.sample_mv;
         end
         if (!shadow_state.usb_latch && shadow_state.average >= shadow_regs.usb_on_mv) begin
            shadow_state.usb_latch = 1'b1;
         end else if (shadow_state.usb_latch
                      && shadow_state.average < shadow_regs.usb_off_mv) begin
            shadow_state.usb_latch = 1'b0;
         end
         if (shadow_state.previous_sample != 0) begin
            diff = mv - int'(shadow_state.previous_sample);
            if (!shadow_state.usb_latch && !shadow_state.charge_flag && diff >= step_mv) begin
               shadow_state.charge_flag = 1'b1;
               stepped = 1'b1;
            end else if ((shadow_state.charge_flag || shadow_state.usb_latch)
                         && -diff >= step_mv) begin
               shadow_state.charge_flag = 1'b0;
               shadow_state.usb_latch = 1'b0;
               stepped = 1'b1;
            end
         end
         elapsed = word.now_ms - shadow_state.slope_anchor_time;
         if (!shadow_state.slope_armed || stepped) begin
            shadow_state.slope_anchor_mv = shadow_state.average;
            shadow_state.slope_anchor_time = word.now_ms;
            shadow_state.slope_armed = 1'b1;
            shadow_state.rise_run = '0;
         end else if (elapsed >= WINDOW_MS) begin
            slope = int'(shadow_state.average) - int'(shadow_state.slope_anchor_mv);
            if (shadow_state.charge_flag && slope < HOLD_MV) shadow_state.charge_flag = 1'b0;
            if (shadow_state.usb_latch && slope <= -SAG_MV) shadow_state.usb_latch = 1'b0;
            if (!shadow_state.usb_latch && !shadow_state.charge_flag) begin
               if (slope >= RISE_MV) begin
                  if (shadow_state.rise_run < RUN_LIMIT) shadow_state.rise_run++;
                  if (shadow_state.rise_run >= RISE_COUNT) shadow_state.charge_flag = 1'b1;
               end else begin
                  shadow_state.rise_run = '0;
               end
            end else begin
               shadow_state.rise_run = '0;
            end
            shadow_state.slope_anchor_mv = shadow_state.average;
            shadow_state.slope_anchor_time = word.now_ms;
         end
         if (shadow_state.usb_latch) shadow_state.charge_flag = 1'b0;
         shadow_state.previous_sample = word.sample_mv;
         // Once cutoff has latched, only a missing cell clears it.
         if (shadow_state.level != LVL_CUTOFF) begin
            if (mv < shadow_regs.cutoff_mv) begin
               if (shadow_state.cutoff_run < RUN_LIMIT) shadow_state.cutoff_run++;
            end else begin
               shadow_state.cutoff_run = '0;
            end
            if (shadow_state.cutoff_run >= CUTOFF_COUNT) begin
               shadow_state.level = LVL_CUTOFF;
            end else if (shadow_state.level == LVL_NORMAL
                         && shadow_state.average < shadow_regs.low_mv) begin
               shadow_state.level = LVL_LOW;
               shadow_state.entry_pulse = 1'b1;
            end else if (shadow_state.level == LVL_LOW
                         && shadow_state.average >= shadow_regs.recover_mv) begin
               shadow_state.level = LVL_NORMAL;
               shadow_state.entry_pulse = 1'b0;
            end
         end
      end
      status.level_state = shadow_state.level;
      status.usb_present = shadow_state.usb_latch;
      status.charging = shadow_state.charge_flag;
      status.alert_due = due;
      status.average_mv = shadow_state.average;
      return status;
   endfunction

   // Driver: offers the oldest pending word and holds it until it is taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (word_taken) void'(pending_words.pop_front());
         if (req_valid && !word_taken) begin
            // The offered word stays on the bus.
         end else if (pending_words.size() != 0
                      && int'($urandom_range(99, 0)) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_words[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here on request.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_served = hold_requests;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (int'($urandom_range(99, 0)) < stall_pct);
      end
   end

   // Monitor: checks each result word, then predicts for each accepted input word.
   always @(posedge clock) begin
      word_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("result word %h arrived with no prediction waiting", rsp_data);
               failures++;
            end else begin
               want_status = expected_status.pop_front();
               results_checked++;
               if (want_status.alert_due) alerts_seen++;
               if (want_status.level_state == LVL_CUTOFF) cutoff_seen++;
               if (want_status.charging) charging_seen++;
               if (want_status.usb_present) usb_seen++;
               if (rsp_data.level_state !== want_status.level_state) begin
                  $error("level_state: expected %0d, actual %0d",
                         want_status.level_state, rsp_data.level_state);
                  failures++;
               end
               if (rsp_data.usb_present !== want_status.usb_present) begin
                  $error("usb_present: expected %0d, actual %0d",
                         want_status.usb_present, rsp_data.usb_present);
                  failures++;
               end
               if (rsp_data.charging !== want_status.charging) begin
                  $error("charging: expected %0d, actual %0d",
                         want_status.charging, rsp_data.charging);
                  failures++;
               end
               if (rsp_data.alert_due !== want_status.alert_due) begin
                  $error("alert_due: expected %0d, actual %0d",
                         want_status.alert_due, rsp_data.alert_due);
                  failures++;
               end
               if (rsp_data.average_mv !== want_status.average_mv) begin
                  $error("average_mv: expected %0d, actual %0d",
                         want_status.average_mv, rsp_data.average_mv);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            word_taken = 1'b1;
            words_taken++;
            expected_status.push_back(predict_status(req_data));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("battery_charge_level_monitor test failed");
            $finish;
         end
      end
   end

   task automatic push_sample(input int mv, input logic [TIME_W-1:0] stamp);
      req_type word;
      word.func = FUNC_SAMPLE;
      word.sample_mv = MV_W'(mv);
      word.now_ms = stamp;
      pending_words.push_back(word);
   endtask

   task automatic push_poll(input logic [TIME_W-1:0] stamp);
      req_type word;
      word.func = FUNC_POLL;
      word.sample_mv = MV_W'($urandom);
      word.now_ms = stamp;
      pending_words.push_back(word);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (index)
         CSR_NO_CELL_MV:      shadow_regs.no_cell_mv = value[MV_W-1:0];
         CSR_USB_ON_MV:       shadow_regs.usb_on_mv = value[MV_W-1:0];
         CSR_USB_OFF_MV:      shadow_regs.usb_off_mv = value[MV_W-1:0];
         CSR_CHARGE_STEP_MV:  shadow_regs.charge_step_mv = value[MV_W-1:0];
         CSR_CUTOFF_MV:       shadow_regs.cutoff_mv = value[MV_W-1:0];
         CSR_LOW_MV:          shadow_regs.low_mv = value[MV_W-1:0];
         CSR_RECOVER_MV:      shadow_regs.recover_mv = value[MV_W-1:0];
         CSR_ALERT_REPEAT_MS: shadow_regs.alert_repeat_ms = value;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input setting_type kind);
      logic [CSR_DATA_W-1:0] v [8];
      int floor_mv;
      case (kind)
         SET_DEFAULT: v = '{2500, 4150, 4100, 40, 3300, 3500, 3600, 60000};
         SET_ZERO:    v = '{0, 0, 0, 0, 0, 0, 0, 0};
         SET_MAX:     v = '{'1, '1, '1, '1, '1, '1, '1, '1};
         SET_TYPICAL: begin
            // Ordered thresholds, so that the walks cross them in a sensible order.
            floor_mv = $urandom_range(3000, 2000);
            v[0] = floor_mv;
            v[4] = floor_mv + $urandom_range(900, 0);
            v[5] = v[4] + $urandom_range(400, 0);
            v[6] = v[5] + $urandom_range(200, 0);
            v[2] = $urandom_range(4300, 3900);
            v[1] = v[2] + $urandom_range(150, 0);
            v[3] = $urandom_range(120, 1);
            v[7] = $urandom_range(120000, 0);
            // The upper bits of the narrow registers must be dropped.
            for (int i = 0; i < 7; i++) begin
               v[i][CSR_DATA_W-1:MV_W] = (CSR_DATA_W - MV_W)'($urandom);
            end
         end
         default: for (int i = 0; i < 8; i++) v[i] = $urandom;
      endcase
      write_register(CSR_NO_CELL_MV, v[0]);
      write_register(CSR_USB_ON_MV, v[1]);
      write_register(CSR_USB_OFF_MV, v[2]);
      write_register(CSR_CHARGE_STEP_MV, v[3]);
      write_register(CSR_CUTOFF_MV, v[4]);
      write_register(CSR_LOW_MV, v[5]);
      write_register(CSR_RECOVER_MV, v[6]);
      write_register(CSR_ALERT_REPEAT_MS, v[7]);
      write_register(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, FIRST_UNUSED_INDEX)),
                     $urandom);
      settings_applied++;
   endtask

   // Mostly voltage walks around the thresholds with drifting timestamps,
   // mixed with polls and a sprinkling of arbitrary words.
   task automatic push_random_items(input int count);
      int left;
      int seg_left;
      int trend;
      int dt_mode;
      int walk;
      int pick;
      int span;
      logic [TIME_W-1:0] stamp;
      req_type word;
      left = count;
      seg_left = 0;
      trend = 0;
      dt_mode = 0;
      walk = 0;
      stamp = $urandom;
      while (left > 0) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(30, 8);
            trend = int'($urandom_range(24, 0)) - 12;
            dt_mode = $urandom_range(2, 0);
            case ($urandom_range(5, 0))
               0: walk = shadow_regs.no_cell_mv;
               1: walk = shadow_regs.usb_on_mv;
               2: walk = shadow_regs.cutoff_mv;
               3: walk = shadow_regs.low_mv;
               4: walk = shadow_regs.recover_mv;
               default: walk = $urandom_range(8191, 0);
            endcase
            walk = walk + int'($urandom_range(300, 0)) - 150;
         end
         pick = $urandom_range(99, 0);
         word = '0;
         if (pick < 8) begin
            word.func = 1'($urandom_range(1, 0));
            case ($urandom_range(3, 0))
               0: word.sample_mv = '0;
               1: word.sample_mv = '1;
               default: word.sample_mv = MV_W'($urandom);
            endcase
            word.now_ms = $urandom;
         end else if (pick < 30) begin
            case ($urandom_range(3, 0))
               0: stamp = stamp + shadow_regs.alert_repeat_ms;
               1: stamp = stamp + shadow_regs.alert_repeat_ms - 1;
               default: stamp = stamp + $urandom_range(5000, 0);
            endcase
            word.func = FUNC_POLL;
            word.sample_mv = MV_W'($urandom);
            word.now_ms = stamp;
         end else begin
            walk = walk + trend + int'($urandom_range(6, 0)) - 3;
            if (pick >= 95) begin
               span = int'(shadow_regs.charge_step_mv) + int'($urandom_range(30, 0));
               if ($urandom_range(1, 0)) walk = walk + span;
               else walk = walk - span;
            end
            if (walk < 0) walk = 0;
            if (walk > 8191) walk = 8191;
            case (dt_mode)
               0: stamp = stamp + $urandom_range(3000, 0);
               1: stamp = stamp + $urandom_range(25000, 15000);
               default: stamp = stamp + $urandom_range(65000, 59000);
            endcase
            word.func = FUNC_SAMPLE;
            word.sample_mv = MV_W'(walk);
            word.now_ms = stamp;
            seg_left--;
         end
         pending_words.push_back(word);
         left--;
      end
   endtask

   task automatic wait_for_drain;
      while (pending_words.size() != 0 || req_valid || expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   setting_type phase_setting [PHASES] = '{SET_TYPICAL, SET_ZERO, SET_MAX, SET_WILD,
                                           SET_TYPICAL, SET_DEFAULT, SET_TYPICAL,
                                           SET_TYPICAL};

   initial begin
      shadow_regs = '{no_cell_mv: 2500, usb_on_mv: 4150, usb_off_mv: 4100,
                      charge_step_mv: 40, cutoff_mv: 3300, low_mv: 3500,
                      recover_mv: 3600, alert_repeat_ms: 60000};
      shadow_state = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings.
      push_poll(32'd0);
      push_sample(0, 10);
      push_sample(3800, 1000);
      push_sample(3850, 2000);
      push_sample(3790, 3000);
      push_sample(8191, 4000);
      push_sample(4300, 70000);
      push_sample(4000, 140000);
      for (int i = 0; i < 4; i++) push_sample(3300, 142000 + i * 1000);
      push_poll(146000);
      push_poll(146001);
      push_poll(206001);
      for (int i = 0; i < 3; i++) push_sample(3000, 207000 + i * 100);
      push_sample(3700, 208000);
      push_poll(300000);
      push_sample(2499, 301000);
      push_sample(3700, 32'hFFFF_FFFF);
      // Elapsed time across the wrap is exactly one slope window.
      push_sample(3720, 32'h0000_EA5F);
      for (int i = 1; i <= 3; i++) push_sample(3720 + i * 15, 32'h0000_EA5F + i * 60000);
      wait_for_drain();

      for (int p = 0; p < PHASES; p++) begin
         apply_setting(phase_setting[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         // Back up the result side while the sender keeps offering.
         if (p == 0) hold_requests++;
         push_random_items(WORDS_PER_PHASE);
         wait_for_drain();
      end

      $display("Ran %0d words through %0d register settings; %0d results checked.",
               words_taken, settings_applied, results_checked);
      $display("Results seen: %0d alerts due, %0d cutoff, %0d charging, %0d usb present.",
               alerts_seen, cutoff_seen, charging_seen, usb_seen);
      if (failures == 0) begin
         $display("battery_charge_level_monitor test passed");
      end else begin
         $display("battery_charge_level_monitor test failed");
      end
      $finish;
   end

endmodule
